/* hdl/work_steal_victim_select_macros.svh */
// Assertion macros shared by the work-stealing victim selector.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef WORK_STEAL_VICTIM_SELECT_MACROS_SVH
`define WORK_STEAL_VICTIM_SELECT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define WSVS_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define WSVS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* hdl/wsvs_pkg.sv */
// Package of the work-stealing victim selector: field widths, status and
// register codes, reset values and the request, result and queue entry types.
// Depends on nothing.
package wsvs_pkg;

	localparam int POS_W      = 32;
	localparam int TIME_W     = 48;
	localparam int WORKER_W   = 4;
	localparam int SLOT_W     = 10;
	localparam int COUNT_W    = 6;
	localparam int STATUS_W   = 3;
	localparam int THR_W      = 16;
	localparam int BACKOFF_W  = 24;
	localparam int WCOUNT_W   = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MAX_MOVES  = 32;
	localparam int CAND1_SHIFT = 4;
	localparam int CAND2_SHIFT = 8;
	localparam int DIV_BPC    = 4;
	localparam int DIV_STEPS  = TIME_W / DIV_BPC;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_REPORTED  = 3'd0;
	localparam status_t ST_BAD_WORKER = 3'd1;
	localparam status_t ST_DISABLED  = 3'd2;
	localparam status_t ST_BACKOFF   = 3'd3;
	localparam status_t ST_NO_VICTIM = 3'd4;
	localparam status_t ST_MOVE      = 3'd5;
	localparam status_t ST_NOTHING   = 3'd6;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_STEAL  = 1'b1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_STEAL_ENABLE = 3'd0;
	localparam cfg_idx_t CFG_WORKER_COUNT = 3'd1;
	localparam cfg_idx_t CFG_THRESHOLD    = 3'd2;
	localparam cfg_idx_t CFG_BACKOFF      = 3'd3;
	localparam cfg_idx_t CFG_BATCH_LIMIT  = 3'd4;

	localparam logic                 RST_STEAL_ENABLE = 1'b1;
	localparam logic [WCOUNT_W-1:0]  RST_WORKER_COUNT = 5'd16;
	localparam logic [THR_W-1:0]     RST_THRESHOLD    = 16'd4;
	localparam logic [BACKOFF_W-1:0] RST_BACKOFF      = 24'd100;
	localparam logic [COUNT_W-1:0]   RST_BATCH_LIMIT  = 6'd8;

	typedef struct packed {
		logic                kind;
		logic [WORKER_W-1:0] worker;
		logic [POS_W-1:0]    head_pos;
		logic [POS_W-1:0]    tail_pos;
		logic [TIME_W-1:0]   now_us;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [WORKER_W-1:0] victim;
		logic [SLOT_W-1:0]   victim_slot;
		logic [SLOT_W-1:0]   stealer_slot;
		logic [COUNT_W-1:0]  moved_count;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] head;
		logic [POS_W-1:0] tail;
		logic [POS_W-1:0] depth;
	} qentry_t;

endpackage

/* hdl/work_steal_victim_select.sv */
// Top level of the work-stealing victim selector: queue state memories,
// sequencer, serial remainder unit and output register.
// Depends on wsvs_pkg and work_steal_victim_select_macros.svh.
//
// Usage: requests enter on req/req_valid and are taken when req_stall is low;
// results leave on rsp/rsp_valid and are taken when rsp_stall is low. The
// configuration port writes one register per cycle with cfg_we.
// A report request gives one result, loaded from the decode state. A steal
// request reads the requesting worker's last attempt time, then either scans
// the depth snapshots of the n active workers or derives two candidates with
// the serial remainder unit and reads their depths. A found victim costs two
// more queue memory reads and a second remainder pass for the ring slots,
// then one move result per cycle while the receiver does not stall, then the
// two write-back states, WB1 and WB2. One request is in flight at a time; the
// queue memory, with its one read port, and the remainder unit set the pace
// of each steal request. The next request is taken as soon as the sequencer is
// back in idle, even while the last result still waits in the output register.
// When the receiver stalls, the sequencer holds until the output register can
// take the next result. Reset clears the entry valid bits so that all queue
// state reads as zero, and loads the register defaults; no clearing pass runs.
module work_steal_victim_select #(
	parameter int MAX_WORKERS = 16,
	parameter int RING_DEPTH  = 1024,
	parameter int SCAN_LIMIT  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  wsvs_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output wsvs_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [wsvs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wsvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wsvs_pkg::*;

	`include "work_steal_victim_select_macros.svh"

	localparam int AW  = $clog2(MAX_WORKERS);
	localparam int NW  = $clog2(MAX_WORKERS + 1);
	localparam int RDW = $clog2(RING_DEPTH + 1);
	localparam int DW  = (NW > RDW) ? NW : RDW;
	localparam int CW  = $clog2(DIV_STEPS);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_BACKOFF = 4'd2;
	localparam logic [3:0] S_SCAN    = 4'd3;
	localparam logic [3:0] S_CDIV    = 4'd4;
	localparam logic [3:0] S_CFIX    = 4'd5;
	localparam logic [3:0] S_CRD1    = 4'd6;
	localparam logic [3:0] S_CRD2    = 4'd7;
	localparam logic [3:0] S_CCMP    = 4'd8;
	localparam logic [3:0] S_CHOSEN  = 4'd9;
	localparam logic [3:0] S_VRD     = 4'd10;
	localparam logic [3:0] S_MRD     = 4'd11;
	localparam logic [3:0] S_SDIV    = 4'd12;
	localparam logic [3:0] S_MOVE    = 4'd13;
	localparam logic [3:0] S_WB1     = 4'd14;
	localparam logic [3:0] S_WB2     = 4'd15;

	function automatic logic [DW-1:0] rem_step(input logic [DW-1:0] r_in,
			input logic [DIV_BPC-1:0] bits, input logic [DW-1:0] d);
		logic [DW:0]   t;
		logic [DW-1:0] r;
		r = r_in;
		for (int j = DIV_BPC - 1; j >= 0; j--) begin
			t = {r, bits[j]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			r = t[DW-1:0];
		end
		return r;
	endfunction

	function automatic logic [NW-1:0] inc_wrap(input logic [NW-1:0] x,
			input logic [NW-1:0] lim);
		logic [NW-1:0] y;
		y = x + 1'b1;
		return (y == lim) ? '0 : y;
	endfunction

	// Configuration registers.
	logic                 steal_enable_q;
	logic [WCOUNT_W-1:0]  worker_count_q;
	logic [THR_W-1:0]     threshold_q;
	logic [BACKOFF_W-1:0] backoff_q;
	logic [COUNT_W-1:0]   batch_q;

	// Queue state memories and their entry valid bits.
	qentry_t                qmem [MAX_WORKERS];
	logic [TIME_W-1:0]      tmem [MAX_WORKERS];
	logic [MAX_WORKERS-1:0] qvalid_q;
	logic [MAX_WORKERS-1:0] tvalid_q;
	qentry_t                q_rdata_q;
	logic [TIME_W-1:0]      t_rdata_q;
	logic                   q_rvalid_q;
	logic                   t_rvalid_q;
	logic                   q_we;
	logic [AW-1:0]          q_waddr;
	qentry_t                q_wdata;
	logic [AW-1:0]          q_raddr;
	logic                   t_we;
	logic [AW-1:0]          t_addr;
	qentry_t                q_rd;
	logic [TIME_W-1:0]      t_rd;

	logic [3:0]  state_q;
	logic [3:0]  state_d;
	req_t        req_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic        emit;
	logic        emit_ok;
	rsp_t        emit_rsp;

	logic [NW-1:0]      n_q;
	logic [NW-1:0]      me_n;
	logic [AW-1:0]      me_a;
	logic               me_bad;
	logic               scan_sel;
	logic [TIME_W-1:0]  t_diff;
	logic [POS_W-1:0]   rep_depth;
	logic [COUNT_W-1:0] limit;

	// Scan and candidate selection.
	logic [NW-1:0]    scan_idx_q;
	logic             scan_pend_s1;
	logic [NW-1:0]    scan_i_s1;
	logic [POS_W-1:0] best_q;
	logic [NW-1:0]    victim_q;
	logic             found_q;
	logic [NW-1:0]    cand1_q;
	logic [NW-1:0]    cand2_q;
	logic [NW-1:0]    c1_adj;
	logic [NW-1:0]    c2_adj;
	logic [NW-1:0]    c2_dup;
	logic [NW-1:0]    c2_fix;
	logic [POS_W-1:0] d1_q;

	// Serial remainder unit, two lanes sharing one divisor.
	logic [TIME_W-1:0] div_a_q;
	logic [TIME_W-1:0] div_b_q;
	logic [DW-1:0]     rem_a_q;
	logic [DW-1:0]     rem_b_q;
	logic [DW-1:0]     divisor_q;
	logic [CW-1:0]     div_cnt_q;

	// Move loop state.
	logic [POS_W-1:0]   vh_q;
	logic [POS_W-1:0]   vt_q;
	logic [POS_W-1:0]   vdep_q;
	logic [POS_W-1:0]   sh_q;
	logic [POS_W-1:0]   mt_q;
	logic [POS_W-1:0]   mdep_q;
	logic [COUNT_W-1:0] k_q;
	logic [POS_W-1:0]   vt_next;
	logic [COUNT_W-1:0] k_next;
	logic               move_go;
	logic               move_cont;
	logic [DW-1:0]      slot_a_next;
	logic [DW-1:0]      slot_b_next;

	assign n_q      = (int'(worker_count_q) > MAX_WORKERS) ? NW'(MAX_WORKERS)
	                                                      : NW'(worker_count_q);
	assign me_bad   = int'(req_q.worker) >= int'(n_q);
	assign me_n     = NW'(req_q.worker);
	assign me_a     = AW'(req_q.worker);
	assign scan_sel = int'(n_q) <= SCAN_LIMIT;
	assign q_rd     = q_rvalid_q ? q_rdata_q : '0;
	assign t_rd     = t_rvalid_q ? t_rdata_q : '0;
	assign t_diff   = req_q.now_us - t_rd;
	assign rep_depth = (req_q.head_pos >= req_q.tail_pos) ?
	                   (req_q.head_pos - req_q.tail_pos) : '0;
	assign limit    = (int'(batch_q) > MAX_MOVES) ? COUNT_W'(MAX_MOVES) : batch_q;

	assign c1_adj = (NW'(rem_a_q) >= me_n) ? NW'(rem_a_q) + 1'b1 : NW'(rem_a_q);
	assign c2_adj = (NW'(rem_b_q) >= me_n) ? NW'(rem_b_q) + 1'b1 : NW'(rem_b_q);
	assign c2_dup = (c2_adj == c1_adj) ? inc_wrap(c2_adj, n_q) : c2_adj;
	assign c2_fix = (c2_dup == me_n) ? inc_wrap(c2_dup, n_q) : c2_dup;

	assign vt_next   = vt_q + 1'b1;
	assign k_next    = k_q + 1'b1;
	assign move_go   = (k_q < limit) &&
	                   ({1'b0, vh_q} > ({1'b0, vt_q} + (POS_W + 1)'(threshold_q)));
	assign move_cont = (k_next < limit) &&
	                   ({1'b0, vh_q} > ({1'b0, vt_next} + (POS_W + 1)'(threshold_q)));
	assign slot_a_next = (rem_a_q == DW'(RING_DEPTH - 1)) ? '0 : rem_a_q + 1'b1;
	assign slot_b_next = (rem_b_q == DW'(RING_DEPTH - 1)) ? '0 : rem_b_q + 1'b1;

	assign emit_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		emit_rsp = '0;
		emit_rsp.last = 1'b1;
		q_we     = 1'b0;
		q_waddr  = me_a;
		q_wdata  = '0;
		q_raddr  = me_a;
		t_we     = 1'b0;
		t_addr   = me_a;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (req_q.kind == KIND_REPORT) begin
					if (emit_ok) begin
						emit = 1'b1;
						state_d = S_IDLE;
						if (me_bad) begin
							emit_rsp.status = ST_BAD_WORKER;
						end else begin
							emit_rsp.status = ST_REPORTED;
							q_we = 1'b1;
							q_wdata = '{head: req_q.head_pos, tail: req_q.tail_pos,
							            depth: rep_depth};
						end
					end
				end else if (!steal_enable_q || n_q < NW'(2)) begin
					if (emit_ok) begin
						emit = 1'b1;
						emit_rsp.status = ST_DISABLED;
						state_d = S_IDLE;
					end
				end else if (me_bad) begin
					if (emit_ok) begin
						emit = 1'b1;
						emit_rsp.status = ST_BAD_WORKER;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_BACKOFF;
				end
			end
			S_BACKOFF: begin
				if (t_diff < TIME_W'(backoff_q)) begin
					if (emit_ok) begin
						emit = 1'b1;
						emit_rsp.status = ST_BACKOFF;
						state_d = S_IDLE;
					end
				end else if (scan_sel) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_CDIV;
				end
			end
			S_SCAN: begin
				q_raddr = AW'(scan_idx_q);
				if (scan_idx_q == n_q && !scan_pend_s1) begin
					state_d = S_CHOSEN;
				end
			end
			S_CDIV: begin
				if (div_cnt_q == CW'(DIV_STEPS - 1)) begin
					state_d = S_CFIX;
				end
			end
			S_CFIX: begin
				state_d = S_CRD1;
			end
			S_CRD1: begin
				q_raddr = AW'(cand1_q);
				state_d = S_CRD2;
			end
			S_CRD2: begin
				q_raddr = AW'(cand2_q);
				state_d = S_CCMP;
			end
			S_CCMP: begin
				state_d = S_CHOSEN;
			end
			S_CHOSEN: begin
				if (!found_q) begin
					if (emit_ok) begin
						emit = 1'b1;
						emit_rsp.status = ST_NO_VICTIM;
						state_d = S_IDLE;
					end
				end else begin
					q_raddr = AW'(victim_q);
					t_we = 1'b1;
					state_d = S_VRD;
				end
			end
			S_VRD: begin
				state_d = S_MRD;
			end
			S_MRD: begin
				state_d = S_SDIV;
			end
			S_SDIV: begin
				if (div_cnt_q == CW'(DIV_STEPS - 1)) begin
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				emit_rsp.victim = WORKER_W'(victim_q);
				if (!move_go) begin
					if (emit_ok) begin
						emit = 1'b1;
						emit_rsp.status = ST_NOTHING;
						state_d = S_IDLE;
					end
				end else if (emit_ok) begin
					emit = 1'b1;
					emit_rsp.status = ST_MOVE;
					emit_rsp.victim_slot = SLOT_W'(rem_a_q);
					emit_rsp.stealer_slot = SLOT_W'(rem_b_q);
					emit_rsp.moved_count = k_next;
					emit_rsp.last = !move_cont;
					if (!move_cont) begin
						state_d = S_WB1;
					end
				end
			end
			S_WB1: begin
				q_we = 1'b1;
				q_waddr = AW'(victim_q);
				q_wdata = '{head: vh_q, tail: vt_q, depth: vdep_q};
				state_d = S_WB2;
			end
			S_WB2: begin
				q_we = 1'b1;
				q_wdata = '{head: sh_q, tail: mt_q, depth: mdep_q};
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[q_waddr] <= q_wdata;
		end
		q_rdata_q <= qmem[q_raddr];
		if (t_we) begin
			tmem[t_addr] <= req_q.now_us;
		end
		t_rdata_q <= tmem[t_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rsp_valid_q    <= 1'b0;
			qvalid_q       <= '0;
			tvalid_q       <= '0;
			q_rvalid_q     <= 1'b0;
			t_rvalid_q     <= 1'b0;
			steal_enable_q <= RST_STEAL_ENABLE;
			worker_count_q <= RST_WORKER_COUNT;
			threshold_q    <= RST_THRESHOLD;
			backoff_q      <= RST_BACKOFF;
			batch_q        <= RST_BATCH_LIMIT;
		end else begin
			state_q    <= state_d;
			q_rvalid_q <= qvalid_q[q_raddr];
			t_rvalid_q <= tvalid_q[t_addr];
			if (q_we) begin
				qvalid_q[q_waddr] <= 1'b1;
			end
			if (t_we) begin
				tvalid_q[t_addr] <= 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_STEAL_ENABLE: steal_enable_q <= cfg_wdata[0];
					CFG_WORKER_COUNT: worker_count_q <= cfg_wdata[WCOUNT_W-1:0];
					CFG_THRESHOLD:    threshold_q    <= cfg_wdata[THR_W-1:0];
					CFG_BACKOFF:      backoff_q      <= cfg_wdata[BACKOFF_W-1:0];
					CFG_BATCH_LIMIT:  batch_q        <= cfg_wdata[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			S_BACKOFF: begin
				scan_idx_q   <= '0;
				scan_pend_s1 <= 1'b0;
				best_q       <= '0;
				found_q      <= 1'b0;
				victim_q     <= '0;
				div_a_q      <= req_q.now_us >> CAND1_SHIFT;
				div_b_q      <= req_q.now_us >> CAND2_SHIFT;
				rem_a_q      <= '0;
				rem_b_q      <= '0;
				divisor_q    <= DW'(n_q - 1'b1);
				div_cnt_q    <= '0;
			end
			S_SCAN: begin
				scan_pend_s1 <= (scan_idx_q < n_q);
				scan_i_s1    <= scan_idx_q;
				if (scan_idx_q < n_q) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (scan_pend_s1 && scan_i_s1 != me_n && q_rd.depth > POS_W'(threshold_q)
						&& q_rd.depth > best_q) begin
					best_q   <= q_rd.depth;
					victim_q <= scan_i_s1;
					found_q  <= 1'b1;
				end
			end
			S_CDIV, S_SDIV: begin
				rem_a_q   <= rem_step(rem_a_q, div_a_q[TIME_W-1 -: DIV_BPC], divisor_q);
				rem_b_q   <= rem_step(rem_b_q, div_b_q[TIME_W-1 -: DIV_BPC], divisor_q);
				div_a_q   <= div_a_q << DIV_BPC;
				div_b_q   <= div_b_q << DIV_BPC;
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			S_CFIX: begin
				cand1_q <= c1_adj;
				cand2_q <= c2_fix;
			end
			S_CRD2: begin
				d1_q <= q_rd.depth;
			end
			S_CCMP: begin
				if (d1_q >= q_rd.depth && d1_q > POS_W'(threshold_q)) begin
					victim_q <= cand1_q;
					found_q  <= 1'b1;
				end else if (q_rd.depth > POS_W'(threshold_q)) begin
					victim_q <= cand2_q;
					found_q  <= 1'b1;
				end
			end
			S_VRD: begin
				vh_q   <= q_rd.head;
				vt_q   <= q_rd.tail;
				vdep_q <= q_rd.depth;
			end
			S_MRD: begin
				sh_q      <= q_rd.head;
				mt_q      <= q_rd.tail;
				mdep_q    <= q_rd.depth;
				div_a_q   <= TIME_W'(vt_q);
				div_b_q   <= TIME_W'(q_rd.head);
				rem_a_q   <= '0;
				rem_b_q   <= '0;
				divisor_q <= DW'(RING_DEPTH);
				div_cnt_q <= '0;
				k_q       <= '0;
			end
			S_MOVE: begin
				if (move_go && emit_ok) begin
					vt_q    <= vt_next;
					sh_q    <= sh_q + 1'b1;
					rem_a_q <= slot_a_next;
					rem_b_q <= slot_b_next;
					k_q     <= k_next;
				end
			end
			default: begin
			end
		endcase
	end

	`WSVS_ASSERT_NOW(a_emit_into_free_reg, emit, !rsp_valid_q || !rsp_stall,
		"result loaded while the output register still holds an untaken result")
	`WSVS_ASSERT_NOW(a_victim_not_stealer, state_q == S_VRD, victim_q != me_n,
		"stealer chose its own queue as victim")
	`WSVS_ASSERT_NOW(a_move_count_bound, emit && emit_rsp.status == ST_MOVE,
		emit_rsp.moved_count != '0 && emit_rsp.moved_count <= limit,
		"move count outside the batch limit")
	`WSVS_ASSERT_NEXT(a_last_move_writes_back,
		emit && emit_rsp.status == ST_MOVE && emit_rsp.last, state_q == S_WB1,
		"final move not followed by queue write-back")
	`WSVS_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, scan_idx_q <= n_q,
		"scan index ran past the active worker count")

endmodule
